>>> rtl/tcprop_pkg.sv
`timescale 1ns / 1ps

package tcprop_pkg;

  localparam logic [5:0] BASE_HDR_LEN     = 6'd20;
  localparam logic [5:0] POS_MAX          = 6'd63;
  localparam logic [5:0] POS_DOFF         = 6'd12;
  localparam logic [5:0] POS_FLAGS        = 6'd13;
  localparam logic [5:0] POS_PORTS_END    = 6'd4;
  localparam logic [7:0] REDIR_MIN_LEN    = 8'd6;
  localparam logic [7:0] REDIR_ADDR_BYTES = 8'd4;
  localparam logic [7:0] OPT_EOL          = 8'd0;
  localparam logic [7:0] OPT_FIRST_LONG   = 8'd2;
  localparam logic [7:0] IP_PROTO_TCP     = 8'd6;
  localparam logic [7:0] KIND_RESET       = 8'h2A;
  localparam int unsigned FLAG_SYN_BIT    = 1;
  localparam int unsigned FLAG_ACK_BIT    = 4;

  typedef struct packed {
    logic [7:0]  hdr_byte;
    logic        first_byte;
    logic        last_byte;
    logic [7:0]  ip_protocol;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
  } in_item_t;

  typedef struct packed {
    logic        matched;
    logic        malformed;
    logic [31:0] redirect_addr;
    logic [31:0] peer_addr;
    logic [31:0] local_addr;
    logic [15:0] peer_port;
    logic [15:0] local_port;
  } result_t;

endpackage

>>> rtl/tcprop_in_if.sv
`timescale 1ns / 1ps

interface tcprop_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  hdr_byte;
  logic        first_byte;
  logic        last_byte;
  logic [7:0]  ip_protocol;
  logic [31:0] ip_src;
  logic [31:0] ip_dst;

  modport source (
    output valid, hdr_byte, first_byte, last_byte, ip_protocol, ip_src, ip_dst,
    input  ready
  );
  modport sink (
    input  valid, hdr_byte, first_byte, last_byte, ip_protocol, ip_src, ip_dst,
    output ready
  );
endinterface

>>> rtl/tcprop_out_if.sv
`timescale 1ns / 1ps

interface tcprop_out_if;
  logic        valid;
  logic        ready;
  logic        matched;
  logic        malformed;
  logic [31:0] redirect_addr;
  logic [31:0] peer_addr;
  logic [31:0] local_addr;
  logic [15:0] peer_port;
  logic [15:0] local_port;

  modport source (
    output valid, matched, malformed, redirect_addr, peer_addr, local_addr,
           peer_port, local_port,
    input  ready
  );
  modport sink (
    input  valid, matched, malformed, redirect_addr, peer_addr, local_addr,
           peer_port, local_port,
    output ready
  );
endinterface

>>> rtl/tcp_redirect_option_parser.sv
`timescale 1ns / 1ps

// TCP header parser for a redirect option. Feed the header one byte per transfer, with
// first_byte on the first one (ip_protocol, ip_src and ip_dst are sampled there) and
// last_byte on the final byte supplied; bytes outside a packet are dropped and a new
// first_byte abandons any packet in progress. Each packet that ends in last_byte gives
// exactly one result transfer, built from the last byte: matched, malformed, the redirect
// address (zero unless the configured option kind was found) and the socket key. The block
// takes one byte per clock, sustained, except that a last byte waits while the result
// register is still full; the per-byte parser update is combinational between an input
// register and a result register, and out_ch.valid rises once the last byte has passed the
// input register and been loaded into the result register. option_kind resets to 42 and is
// to be written through cfg_wr_en and cfg_wr_data while no packet is in flight; the block itself does not enforce this.
module tcp_redirect_option_parser (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  tcprop_in_if.sink  in_ch,
  tcprop_out_if.source out_ch
);
  import tcprop_pkg::*;

  logic     s_valid;
  in_item_t s_item;
  logic     take;
  logic     load;
  logic     out_free;
  result_t  result;

  tcprop_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .take    (take),
    .s_valid (s_valid),
    .s_item  (s_item)
  );

  tcprop_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_valid     (s_valid),
    .s_item      (s_item),
    .out_free    (out_free),
    .take        (take),
    .load        (load),
    .result      (result)
  );

  tcprop_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .result   (result),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

>>> rtl/tcprop_in_stage.sv
`timescale 1ns / 1ps

module tcprop_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  tcprop_in_if.sink           in_ch,
  input  logic                take,
  output logic                s_valid,
  output tcprop_pkg::in_item_t s_item
);
  import tcprop_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     in_xfer;

  assign in_ch.ready = !valid_r || take;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_xfer) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.hdr_byte    <= in_ch.hdr_byte;
      item_r.first_byte  <= in_ch.first_byte;
      item_r.last_byte   <= in_ch.last_byte;
      item_r.ip_protocol <= in_ch.ip_protocol;
      item_r.ip_src      <= in_ch.ip_src;
      item_r.ip_dst      <= in_ch.ip_dst;
    end
  end

  assign s_valid = valid_r;
  assign s_item  = item_r;

endmodule

>>> rtl/tcprop_parse.sv
`timescale 1ns / 1ps

module tcprop_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 s_valid,
  input  tcprop_pkg::in_item_t s_item,
  input  logic                 out_free,
  output logic                 take,
  output logic                 load,
  output tcprop_pkg::result_t  result
);
  import tcprop_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIXED,
    PH_KIND,
    PH_LEN,
    PH_RLEN,
    PH_SKIP,
    PH_CAPTURE,
    PH_END
  } phase_t;

  phase_t      phase_r, phase_nxt, ph;
  logic [5:0]  pos_r, pos_nxt, pos;
  logic [5:0]  hl_r, hl_nxt, hl;
  logic [7:0]  left_r, left_nxt, left;
  logic [31:0] addr_r, addr_nxt, addr;
  logic [31:0] ports_r, ports_nxt, ports;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic        tcp_r, tcp_nxt;
  logic        syn_r, syn_nxt;
  logic        ack_r, ack_nxt;
  logic        found_r, found_nxt;
  logic        bad_r, bad_nxt;
  logic [7:0]  kind_r;

  logic [7:0]  b;
  logic        first;
  logic        active;
  logic        produce;
  logic        kind_hit;
  logic [8:0]  opt_end;
  logic        len_over;
  logic [6:0]  pos_inc;
  logic [5:0]  need;
  logic        upd;

  always_comb begin
    b        = s_item.hdr_byte;
    first    = s_item.first_byte;
    active   = first || (phase_r != PH_IDLE);
    produce  = active && s_item.last_byte;

    // a new packet restarts from clean state
    if (first) begin
      pos   = '0;
      hl    = '0;
      ph    = PH_FIXED;
      left  = '0;
      addr  = '0;
      ports = '0;
    end else begin
      pos   = pos_r;
      hl    = hl_r;
      ph    = phase_r;
      left  = left_r;
      addr  = addr_r;
      ports = ports_r;
    end

    pos_nxt   = (pos == POS_MAX) ? pos : pos + 6'd1;
    hl_nxt    = hl;
    phase_nxt = ph;
    left_nxt  = left;
    addr_nxt  = addr;
    ports_nxt = ports;
    src_nxt   = first ? s_item.ip_src : src_r;
    dst_nxt   = first ? s_item.ip_dst : dst_r;
    tcp_nxt   = first ? (s_item.ip_protocol == IP_PROTO_TCP) : tcp_r;
    syn_nxt   = first ? 1'b0 : syn_r;
    ack_nxt   = first ? 1'b0 : ack_r;
    found_nxt = first ? 1'b0 : found_r;
    bad_nxt   = first ? 1'b0 : bad_r;

    kind_hit = (b == kind_r);
    pos_inc  = {1'b0, pos} + 7'd1;
    opt_end  = {3'b000, pos} + {1'b0, b} - 9'd1;
    len_over = opt_end > {3'b000, hl};

    if (pos < BASE_HDR_LEN) begin
      if (pos < POS_PORTS_END) begin
        ports_nxt = {ports[23:0], b};
      end
      if (pos == POS_DOFF) begin
        hl_nxt = {b[7:4], 2'b00};
        if (hl_nxt < BASE_HDR_LEN) begin
          bad_nxt = 1'b1;
        end
      end
      if (pos == POS_FLAGS) begin
        if (b[FLAG_SYN_BIT]) begin
          syn_nxt = 1'b1;
        end
        if (b[FLAG_ACK_BIT]) begin
          ack_nxt = 1'b1;
        end
      end
      if (pos == BASE_HDR_LEN - 6'd1) begin
        phase_nxt = (hl_nxt > BASE_HDR_LEN && !bad_nxt) ? PH_KIND : PH_END;
      end
    end else if (pos < hl) begin
      unique case (ph)
        PH_KIND: begin
          if (kind_hit || b >= OPT_FIRST_LONG) begin
            if (pos_inc >= {1'b0, hl}) begin
              bad_nxt   = 1'b1;
              phase_nxt = PH_END;
            end else begin
              phase_nxt = kind_hit ? PH_RLEN : PH_LEN;
            end
          end else if (b == OPT_EOL) begin
            phase_nxt = PH_END;
          end
        end
        PH_LEN: begin
          if (b < OPT_FIRST_LONG || len_over) begin
            bad_nxt   = 1'b1;
            phase_nxt = PH_END;
          end else begin
            left_nxt  = b - OPT_FIRST_LONG;
            phase_nxt = (left_nxt != '0) ? PH_SKIP : PH_KIND;
          end
        end
        PH_RLEN: begin
          if (b < REDIR_MIN_LEN || len_over) begin
            bad_nxt   = 1'b1;
            phase_nxt = PH_END;
          end else begin
            left_nxt  = REDIR_ADDR_BYTES;
            phase_nxt = PH_CAPTURE;
          end
        end
        PH_SKIP: begin
          left_nxt = left - 8'd1;
          if (left_nxt == '0) begin
            phase_nxt = PH_KIND;
          end
        end
        PH_CAPTURE: begin
          addr_nxt = {addr[23:0], b};
          left_nxt = left - 8'd1;
          if (left_nxt == '0) begin
            found_nxt = 1'b1;
            phase_nxt = PH_END;
          end
        end
        PH_IDLE, PH_FIXED, PH_END: begin
        end
        default: begin
        end
      endcase
    end

    // truncated header on the last byte
    need = (hl_nxt > BASE_HDR_LEN) ? hl_nxt : BASE_HDR_LEN;
    if (s_item.last_byte) begin
      if (pos_inc < {1'b0, need}) begin
        bad_nxt = 1'b1;
      end
      phase_nxt = PH_IDLE;
    end

    result.matched       = tcp_nxt && syn_nxt && ack_nxt && found_nxt && !bad_nxt;
    result.malformed     = bad_nxt;
    result.redirect_addr = found_nxt ? addr_nxt : '0;
    result.peer_addr     = src_nxt;
    result.local_addr    = dst_nxt;
    result.peer_port     = ports_nxt[31:16];
    result.local_port    = ports_nxt[15:0];
  end

  assign take = s_valid && (!produce || out_free);
  assign load = take && produce;
  assign upd  = take && active;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      found_r <= 1'b0;
      bad_r   <= 1'b0;
      kind_r  <= KIND_RESET;
    end else begin
      if (cfg_wr_en) begin
        kind_r <= cfg_wr_data;
      end
      if (upd) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        found_r <= found_nxt;
        bad_r   <= bad_nxt;
        hl_r    <= hl_nxt;
        left_r  <= left_nxt;
        addr_r  <= addr_nxt;
        ports_r <= ports_nxt;
        src_r   <= src_nxt;
        dst_r   <= dst_nxt;
        tcp_r   <= tcp_nxt;
        syn_r   <= syn_nxt;
        ack_r   <= ack_nxt;
      end
    end
  end

`ifndef SYNTHESIS
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> phase_r == PH_IDLE)
    else $error("parser not idle after result");

  a_found_stops_walk: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (phase_r == PH_END || phase_r == PH_IDLE))
    else $error("option walk continues after capture");

  a_bad_stops_walk: assert property (@(posedge clk) disable iff (!rst_n)
    bad_r |-> (phase_r == PH_FIXED || phase_r == PH_END || phase_r == PH_IDLE))
    else $error("option walk continues on malformed header");

  a_first_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    take && first |=> pos_r == 6'd1)
    else $error("byte position not restarted by first byte");
`endif

endmodule

>>> rtl/tcprop_out_stage.sv
`timescale 1ns / 1ps

module tcprop_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  tcprop_pkg::result_t result,
  output logic                out_free,
  tcprop_out_if.source        out_ch
);
  import tcprop_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.matched       = res_r.matched;
  assign out_ch.malformed     = res_r.malformed;
  assign out_ch.redirect_addr = res_r.redirect_addr;
  assign out_ch.peer_addr     = res_r.peer_addr;
  assign out_ch.local_addr    = res_r.local_addr;
  assign out_ch.peer_port     = res_r.peer_port;
  assign out_ch.local_port    = res_r.local_port;

endmodule
